### hdl/spq_pkg.sv
package spq_pkg;

	// Queue sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int REM_W       = $clog2(MAX_RESULTS + 1);
	localparam int CMP_W       = 9;
	localparam int OCC_W       = 5;
	localparam int DATA_W      = 32;

	// Request codes
	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_POP   = 2'd1;
	localparam logic [1:0] REQ_MULTI = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef enum logic {
		CTL_IDLE,
		CTL_MULTI
	} ctl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic       push;
		logic       pop;
		logic       emit;
		logic       with_entry;
		logic [1:0] status;
		logic       last;
	} spq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic             empty;
		logic             full;
		logic             out_free;
		logic [CNT_W-1:0] count;
	} spq_stat_t;

endpackage

### hdl/spq_ctrl.sv
module spq_ctrl import spq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] pop_count,
	input  spq_stat_t  stat,
	output spq_cmd_t   cmd
);

	ctl_state_t       state_q, state_d;
	logic [REM_W-1:0] rem_q, rem_d;
	logic [CMP_W-1:0] clip_a, clip_b;
	logic [REM_W-1:0] clip;
	logic             accept;

	// State and remaining-entry counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			rem_q   <= rem_d;
		end
	end

	// Clip the multipop count to held entries and to the result limit
	always_comb begin
		clip_a = CMP_W'(pop_count);
		if (clip_a > CMP_W'(stat.count))
			clip_a = CMP_W'(stat.count);
		clip_b = clip_a;
		if (clip_b > CMP_W'(MAX_RESULTS))
			clip_b = CMP_W'(MAX_RESULTS);
		clip = REM_W'(clip_b);
	end

	assign in_stall = !((state_q == CTL_IDLE) && stat.out_free);
	assign accept   = in_valid && !in_stall;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		rem_d   = rem_q;
		cmd     = '0;
		case (state_q)
			CTL_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_PUSH: begin
							cmd.emit   = 1'b1;
							cmd.last   = 1'b1;
							cmd.push   = !stat.full;
							cmd.status = stat.full ? STAT_FULL : STAT_OK;
						end
						REQ_POP: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							if (stat.empty) begin
								cmd.status = STAT_EMPTY;
							end else begin
								cmd.pop        = 1'b1;
								cmd.with_entry = 1'b1;
								cmd.status     = STAT_OK;
							end
						end
						REQ_MULTI: begin
							cmd.emit = 1'b1;
							if (stat.empty) begin
								cmd.status = STAT_EMPTY;
								cmd.last   = 1'b1;
							end else if (clip == '0) begin
								cmd.status = STAT_OK;
								cmd.last   = 1'b1;
							end else begin
								// first entry leaves in the accepting cycle
								cmd.pop        = 1'b1;
								cmd.with_entry = 1'b1;
								cmd.status     = STAT_OK;
								cmd.last       = (clip == REM_W'(1));
								rem_d          = clip - REM_W'(1);
								if (clip != REM_W'(1))
									state_d = CTL_MULTI;
							end
						end
						default: begin
							// unused code: taken, no result
						end
					endcase
				end
			end
			CTL_MULTI: begin
				if (stat.out_free) begin
					cmd.emit       = 1'b1;
					cmd.pop        = 1'b1;
					cmd.with_entry = 1'b1;
					cmd.status     = STAT_OK;
					cmd.last       = (rem_q == REM_W'(1));
					rem_d          = rem_q - REM_W'(1);
					if (rem_q == REM_W'(1))
						state_d = CTL_IDLE;
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

endmodule

### hdl/spq_dpath.sv
module spq_dpath import spq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [DATA_W-1:0] item_value,
	input  logic signed [DATA_W-1:0] item_priority,
	input  spq_cmd_t                 cmd,
	output spq_stat_t                stat,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] out_value,
	output logic signed [DATA_W-1:0] out_priority,
	output logic                     entry_valid,
	output logic [1:0]               status,
	output logic [OCC_W-1:0]         occupancy,
	output logic                     last
);

	logic signed [DATA_W-1:0] val_q [QUEUE_DEPTH];
	logic signed [DATA_W-1:0] pri_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]         count_q, count_d;
	logic [QUEUE_DEPTH-1:0]   ge;
	logic                     out_valid_q;

	// Cells that keep their place on a push: held and not lower priority
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++)
			ge[i] = (CNT_W'(i) < count_q) && (pri_q[i] >= item_priority);
	end

	// Shifting cell array, head in cell zero
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (!ge[i]) begin
					if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
						val_q[i] <= item_value;
						pri_q[i] <= item_priority;
					end else begin
						val_q[i] <= val_q[(i == 0) ? 0 : i - 1];
						pri_q[i] <= pri_q[(i == 0) ? 0 : i - 1];
					end
				end
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				val_q[i] <= val_q[i + 1];
				pri_q[i] <= pri_q[i + 1];
			end
		end
	end

	// Occupancy
	always_comb begin
		count_d = count_q;
		if (cmd.push)
			count_d = count_q + CNT_W'(1);
		else if (cmd.pop)
			count_d = count_q - CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else
			count_q <= count_d;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value    <= cmd.with_entry ? val_q[0] : '0;
			out_priority <= cmd.with_entry ? pri_q[0] : '0;
			entry_valid  <= cmd.with_entry;
			status       <= cmd.status;
			occupancy    <= OCC_W'(count_d);
			last         <= cmd.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q >= CNT_W'(QUEUE_DEPTH));
	assign stat.out_free = !out_valid_q || !out_stall;
	assign stat.count    = count_q;

endmodule

### hdl/sorted_priority_queue_core.sv
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_stall   req_type, item_value, item_priority, pop_count
// out       result     out_valid / out_stall out_value, out_priority, entry_valid, status,
//                                            occupancy, last
//
// A push or pop is done in the accepting cycle; a multipop of n pops one entry per cycle
// while output is free, the first in the accepting cycle, and stalls input till the last.
// A new request is taken while idle and the result register is empty or being drained.
// Reset clears the occupancy and the controller; cell contents are not cleared.
// A stalled result holds in the output register and stalls the input side.
module sorted_priority_queue_core import spq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               req_type,
	input  logic signed [DATA_W-1:0] item_value,
	input  logic signed [DATA_W-1:0] item_priority,
	input  logic [7:0]               pop_count,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] out_value,
	output logic signed [DATA_W-1:0] out_priority,
	output logic                     entry_valid,
	output logic [1:0]               status,
	output logic [OCC_W-1:0]         occupancy,
	output logic                     last
);

	spq_cmd_t  cmd;
	spq_stat_t stat;

	// Sequencer
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.pop_count (pop_count),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Cell array and result register
	spq_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_value    (item_value),
		.item_priority (item_priority),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_value     (out_value),
		.out_priority  (out_priority),
		.entry_valid   (entry_valid),
		.status        (status),
		.occupancy     (occupancy),
		.last          (last)
	);

endmodule

### bench/tb_sorted_priority_queue_core.sv
module tb_sorted_priority_queue_core;
	import spq_pkg::*;

	// Request code with no meaning: the core must ignore it
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int RANDOM_REQUESTS = 220;
	localparam int CALM_TAIL       = 40;
	localparam int CYCLE_LIMIT     = 250000;
	localparam int DRAIN_CYCLES    = 40;

	// One result as seen on the output channel
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
		logic                     entry_valid;
		logic [1:0]               status;
		logic [OCC_W-1:0]         occupancy;
		logic                     last;
	} queue_reply_t;

	// Shadow copy of the sorted queue plus the list of replies still owed
	class PriorityQueueScoreboard;
		logic signed [DATA_W-1:0] slot_val [QUEUE_DEPTH];
		logic signed [DATA_W-1:0] slot_pri [QUEUE_DEPTH];
		int held;
		int fails;
		queue_reply_t awaited [$];

		function new();
			held = 0;
			fails = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void add_reply(input logic signed [DATA_W-1:0] v, p, input logic ev,
				input logic [1:0] st, input logic lst);
			queue_reply_t r;
			r.value = v;
			r.prio = p;
			r.entry_valid = ev;
			r.status = st;
			r.occupancy = held[OCC_W-1:0];
			r.last = lst;
			awaited.push_back(r);
		endfunction

		// Remove the head cell and owe a reply carrying it
		function void take_head(input logic lst);
			logic signed [DATA_W-1:0] v;
			logic signed [DATA_W-1:0] p;
			v = slot_val[0];
			p = slot_pri[0];
			for (int i = 1; i < held; i++) begin
				slot_val[i-1] = slot_val[i];
				slot_pri[i-1] = slot_pri[i];
			end
			held--;
			add_reply(v, p, 1'b1, STAT_OK, lst);
		endfunction

		// Work out the replies owed for one accepted request
		function void note_request(input logic [1:0] req, input logic signed [DATA_W-1:0] v, p,
				input logic [7:0] cnt);
			int pos;
			int n;
			case (req)
			REQ_PUSH: begin
				if (held >= QUEUE_DEPTH) begin
					add_reply(0, 0, 1'b0, STAT_FULL, 1'b1);
				end else begin
					// insert ahead of the first strictly lower priority
					pos = 0;
					while (pos < held && slot_pri[pos] >= p)
						pos++;
					for (int i = held; i > pos; i--) begin
						slot_val[i] = slot_val[i-1];
						slot_pri[i] = slot_pri[i-1];
					end
					slot_val[pos] = v;
					slot_pri[pos] = p;
					held++;
					add_reply(0, 0, 1'b0, STAT_OK, 1'b1);
				end
			end
			REQ_POP: begin
				if (held == 0)
					add_reply(0, 0, 1'b0, STAT_EMPTY, 1'b1);
				else
					take_head(1'b1);
			end
			REQ_MULTI: begin
				n = cnt;
				if (n > held)
					n = held;
				if (n > MAX_RESULTS)
					n = MAX_RESULTS;
				if (held == 0)
					add_reply(0, 0, 1'b0, STAT_EMPTY, 1'b1);
				else if (n == 0)
					add_reply(0, 0, 1'b0, STAT_OK, 1'b1);
				else
					for (int k = 0; k < n; k++)
						take_head(k == n - 1);
			end
			default: ;
			endcase
		endfunction

		function void check_field(input string name, input logic [DATA_W-1:0] want,
				input logic [DATA_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %h, got %h", name, want, got);
				fails++;
			end
		endfunction

		function void check_reply(input queue_reply_t got);
			queue_reply_t want;
			if (awaited.size() == 0) begin
				$error("reply with nothing owed: value %h priority %h status %0d",
					got.value, got.prio, got.status);
				fails++;
				return;
			end
			want = awaited.pop_front();
			check_field("out_value", want.value, got.value);
			check_field("out_priority", want.prio, got.prio);
			check_field("entry_valid", want.entry_valid, got.entry_valid);
			check_field("status", want.status, got.status);
			check_field("occupancy", want.occupancy, got.occupancy);
			check_field("last", want.last, got.last);
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               req_type;
	logic signed [DATA_W-1:0] item_value;
	logic signed [DATA_W-1:0] item_priority;
	logic [7:0]               pop_count;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] out_value;
	logic signed [DATA_W-1:0] out_priority;
	logic                     entry_valid;
	logic [1:0]               status;
	logic [OCC_W-1:0]         occupancy;
	logic                     last;

	bit calm = 1'b0;
	bit sender_quiet = 1'b0;
	int cycle_count = 0;
	PriorityQueueScoreboard sb = new();

	sorted_priority_queue_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.item_value   (item_value),
		.item_priority(item_priority),
		.pop_count    (pop_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_value    (out_value),
		.out_priority (out_priority),
		.entry_valid  (entry_valid),
		.status       (status),
		.occupancy    (occupancy),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_priority_queue_core: mismatch");
			$finish;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_reply('{out_value, out_priority, entry_valid, status, occupancy, last});
	end

	// Receiver back-pressure: free runs and stall bursts
	initial begin
		int run;
		forever begin
			if (calm) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				run = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
				out_stall <= 1'b0;
				repeat (run) @(posedge clk);
				out_stall <= 1'b1;
				repeat ($urandom_range(11, 1)) @(posedge clk);
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] rand_word();
		case ($urandom_range(7))
		0: return 32'sh8000_0000;
		1: return 32'sh7fff_ffff;
		2: return 32'sh0000_0000;
		3: return -32'sd1;
		default: return $urandom;
		endcase
	endfunction

	// Narrow range for two draws in five so equal priorities are common
	function automatic logic signed [DATA_W-1:0] rand_prio();
		if ($urandom_range(4) < 2)
			return $signed($urandom_range(6)) - 3;
		return rand_word();
	endfunction

	function automatic logic [7:0] rand_count();
		case ($urandom_range(9))
		0, 1:    return 8'd0;
		7, 8:    return 8'($urandom_range(20, 5));
		9:       return 8'($urandom_range(255));
		default: return 8'($urandom_range(4, 1));
		endcase
	endfunction

	// Present one request and hold it until the core takes it
	task automatic issue(input logic [1:0] req, input logic signed [DATA_W-1:0] v, p,
			input logic [7:0] cnt);
		int gap;
		gap = 0;
		if (!calm && !sender_quiet && $urandom_range(3) == 0)
			gap = $urandom_range(11, 1);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= req;
		item_value    <= v;
		item_priority <= p;
		pop_count     <= cnt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(req, v, p, cnt);
	endtask

	// Hold off the sender until every owed reply has come back
	task automatic drain_all();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Stimulus
	initial begin
		int accepted;
		int phase_kind;
		int phase_len;
		int push_share;
		int roll;
		bit paused;

		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		req_type      <= REQ_PUSH;
		item_value    <= '0;
		item_priority <= '0;
		pop_count     <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue, ignored code, extremes, ties, clipping
		issue(REQ_POP, 0, 0, 8'hff);
		issue(REQ_MULTI, 32'sh7fff_ffff, 32'sh7fff_ffff, 8'd5);
		issue(REQ_UNUSED, -32'sd1, -32'sd1, 8'hff);
		issue(REQ_PUSH, 32'sh7fff_ffff, 0, 8'h00);
		issue(REQ_PUSH, 32'sh8000_0000, 32'sh7fff_ffff, 8'haa);
		issue(REQ_PUSH, 0, 32'sh8000_0000, 8'h55);
		issue(REQ_PUSH, -32'sd1, 0, 8'hff);
		issue(REQ_PUSH, 32'sd1, -32'sd1, 8'h00);
		issue(REQ_MULTI, 32'sh5555_5555, 32'shaaaa_aaaa, 8'd0);
		issue(REQ_POP, 32'shaaaa_aaaa, 32'sh5555_5555, 8'd0);
		issue(REQ_MULTI, 0, 0, 8'd255);
		issue(REQ_POP, 0, 0, 8'd0);
		issue(REQ_PUSH, 32'sd10, 32'sd5, 8'd0);
		issue(REQ_PUSH, 32'sd11, 32'sd5, 8'd0);
		issue(REQ_PUSH, 32'sd12, 32'sd5, 8'd0);
		issue(REQ_PUSH, 32'sd13, 32'sd6, 8'd0);
		issue(REQ_MULTI, 0, 0, 8'd2);
		issue(REQ_POP, 0, 0, 8'd0);
		issue(REQ_POP, 0, 0, 8'd0);
		issue(REQ_MULTI, 0, 0, 8'd1);

		// Random phases: fill-heavy, drain-heavy and mixed
		accepted = 0;
		paused = 1'b0;
		while (accepted < RANDOM_REQUESTS) begin
			phase_kind = $urandom_range(2);
			phase_len = $urandom_range(30, 8);
			sender_quiet = ($urandom_range(3) == 0);
			push_share = (phase_kind == 0) ? 85 : (phase_kind == 1) ? 25 : 52;
			for (int k = 0; k < phase_len && accepted < RANDOM_REQUESTS; k++) begin
				calm = (accepted >= RANDOM_REQUESTS - CALM_TAIL);
				if (!paused && accepted >= RANDOM_REQUESTS / 2) begin
					drain_all();
					paused = 1'b1;
				end
				roll = $urandom_range(99);
				if (roll < 3) begin
					issue(REQ_UNUSED, rand_word(), rand_word(), 8'($urandom));
				end else begin
					if (roll < push_share)
						issue(REQ_PUSH, rand_word(), rand_prio(), 8'($urandom));
					else if (roll % 2)
						issue(REQ_POP, rand_word(), rand_word(), 8'($urandom));
					else
						issue(REQ_MULTI, rand_word(), rand_word(), rand_count());
					accepted++;
				end
			end
		end

		// Wind down and report
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fails == 0)
			$display("sorted_priority_queue_core: match");
		else
			$display("sorted_priority_queue_core: mismatch");
		$finish;
	end

endmodule

### sorted_priority_queue_core.f
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_dpath.sv
hdl/sorted_priority_queue_core.sv
bench/tb_sorted_priority_queue_core.sv
